>>> design/fasp_pkg.sv
// shared types, constants and lookup functions for the fasta residue stream parser
`default_nettype none
package fasp_pkg;

	typedef enum logic [1:0] {
		KIND_RESIDUE  = 2'd0,
		KIND_SENTINEL = 2'd1,
		KIND_RECORD   = 2'd2,
		KIND_ERROR    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_INVALID_RESIDUE = 2'd0,
		ERR_EMPTY_HEADER    = 2'd1,
		ERR_TOO_MANY        = 2'd2,
		ERR_NO_SEQUENCES    = 2'd3
	} err_t;

	localparam logic [7:0] HEADER_MARK = 8'd62;
	localparam logic [7:0] NEWLINE     = 8'd10;
	localparam logic [7:0] NUC_LIMIT   = 8'd251;
	localparam logic [7:0] AMINO_LIMIT = 8'd235;
	localparam int QUEUE_DEPTH = 4;

	// results of one request, at most two
	typedef struct packed {
		kind_t       kind0;
		kind_t       kind1;
		logic        two;
		logic [7:0]  symbol;
		logic [7:0]  number;
		logic [31:0] length;
		logic [31:0] start;
		err_t        code;
	} bundle_t;

	function automatic logic is_blank(input logic [7:0] b);
		is_blank = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_nuc(input logic [7:0] b);
		is_nuc = (b == 8'd65) || (b == 8'd67) || (b == 8'd71) || (b == 8'd84);
	endfunction

	function automatic logic is_amino(input logic [7:0] b);
		case (b) inside
			8'd65, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd75, 8'd76,
			8'd77, 8'd78, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd86, 8'd87, 8'd89: begin
				is_amino = 1'b1;
			end
			default: begin
				is_amino = 1'b0;
			end
		endcase
	endfunction

	// index is below the limit, so index + 1 never wraps
	function automatic logic [7:0] sentinel_for(input logic mode, input logic [7:0] idx);
		logic [7:0] s;
		s = idx + 8'd1;
		if (mode) begin
			case (s) inside
				8'd65: begin
					sentinel_for = 8'd66;
				end
				[8'd67:8'd73]: begin
					sentinel_for = 8'd74;
				end
				[8'd75:8'd78]: begin
					sentinel_for = 8'd79;
				end
				[8'd80:8'd84]: begin
					sentinel_for = 8'd85;
				end
				8'd86, 8'd87: begin
					sentinel_for = 8'd88;
				end
				8'd89: begin
					sentinel_for = 8'd90;
				end
				default: begin
					sentinel_for = s;
				end
			endcase
		end else begin
			case (s) inside
				8'd65, 8'd67, 8'd71, 8'd84: begin
					sentinel_for = s + 8'd1;
				end
				default: begin
					sentinel_for = s;
				end
			endcase
		end
	endfunction

endpackage
`default_nettype wire

>>> design/fasp_front.sv
// front end: accepts text bytes, tracks parse state and builds result bundles
`default_nettype none
module fasp_front #(
	parameter int POSITION_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 text_valid,
	input  wire logic [7:0]           text_byte,
	input  wire logic                 end_of_text,
	input  wire logic                 queue_full,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_mode,
	output logic                      push,
	output fasp_pkg::bundle_t         bundle
);

	localparam int WIDE = (POSITION_BITS > 32) ? POSITION_BITS : 32;

	logic                     mode_q;
	logic                     at_line_start_q, at_line_start_n;
	logic                     in_header_q, in_header_n;
	logic                     has_name_q, has_name_n;
	logic                     seq_open_q, seq_open_n;
	logic                     halted_q, halted_n;
	logic [POSITION_BITS-1:0] length_q, length_n;
	logic [POSITION_BITS-1:0] start_q, start_n;
	logic [POSITION_BITS-1:0] position_q, position_n;
	logic [7:0]               count_q, count_n;
	logic                     accept;
	logic                     has_record;
	logic [7:0]               upper;
	logic                     in_alpha;
	logic [7:0]               limit;
	logic [7:0]               count_inc;
	logic [POSITION_BITS-1:0] position_inc;
	logic [POSITION_BITS-1:0] length_inc;

	function automatic logic [31:0] clip(input logic [POSITION_BITS-1:0] v);
		logic [WIDE-1:0] e;
		e = WIDE'(v);
		clip = (e > WIDE'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : e[31:0];
	endfunction

	assign accept       = text_valid && !queue_full;
	assign has_record   = seq_open_q && (length_q != '0);
	assign upper        = (text_byte >= 8'd97 && text_byte <= 8'd122) ?
	                      (text_byte - 8'd32) : text_byte;
	assign in_alpha     = mode_q ? fasp_pkg::is_amino(upper) : fasp_pkg::is_nuc(upper);
	assign limit        = mode_q ? fasp_pkg::AMINO_LIMIT : fasp_pkg::NUC_LIMIT;
	assign count_inc    = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
	assign position_inc = (position_q == '1) ? position_q : position_q + POSITION_BITS'(1);
	assign length_inc   = (length_q == '1) ? length_q : length_q + POSITION_BITS'(1);

	always_comb begin
		at_line_start_n = at_line_start_q;
		in_header_n     = in_header_q;
		has_name_n      = has_name_q;
		seq_open_n      = seq_open_q;
		halted_n        = halted_q;
		length_n        = length_q;
		start_n         = start_q;
		position_n      = position_q;
		count_n         = count_q;
		push            = 1'b0;
		bundle.kind0    = fasp_pkg::KIND_RESIDUE;
		bundle.kind1    = fasp_pkg::KIND_SENTINEL;
		bundle.two      = 1'b0;
		bundle.symbol   = 8'd0;
		bundle.number   = 8'd0;
		bundle.length   = 32'd0;
		bundle.start    = 32'd0;
		bundle.code     = fasp_pkg::ERR_INVALID_RESIDUE;
		if (accept && !halted_q) begin
			if (end_of_text) begin
				if (in_header_q && !has_name_q) begin
					push        = 1'b1;
					bundle.kind0 = fasp_pkg::KIND_ERROR;
					bundle.code  = fasp_pkg::ERR_EMPTY_HEADER;
					halted_n    = 1'b1;
				end else if (!has_record && count_q == 8'd0) begin
					push        = 1'b1;
					bundle.kind0 = fasp_pkg::KIND_ERROR;
					bundle.code  = fasp_pkg::ERR_NO_SEQUENCES;
					halted_n    = 1'b1;
				end else begin
					if (has_record) begin
						push          = 1'b1;
						bundle.kind0  = fasp_pkg::KIND_RECORD;
						bundle.number = count_q;
						bundle.length = clip(length_q);
						bundle.start  = clip(start_q);
					end
					at_line_start_n = 1'b1;
					in_header_n     = 1'b0;
					has_name_n      = 1'b0;
					seq_open_n      = 1'b0;
					length_n        = '0;
					start_n         = '0;
					position_n      = '0;
					count_n         = 8'd0;
				end
			end else if (text_byte == fasp_pkg::NEWLINE) begin
				if (in_header_q && !has_name_q) begin
					push        = 1'b1;
					bundle.kind0 = fasp_pkg::KIND_ERROR;
					bundle.code  = fasp_pkg::ERR_EMPTY_HEADER;
					halted_n    = 1'b1;
				end
				in_header_n     = 1'b0;
				at_line_start_n = 1'b1;
			end else if (at_line_start_q && text_byte == fasp_pkg::HEADER_MARK) begin
				at_line_start_n = 1'b0;
				start_n         = position_q;
				if (has_record) begin
					push          = 1'b1;
					bundle.kind0  = fasp_pkg::KIND_RECORD;
					bundle.number = count_q;
					bundle.length = clip(length_q);
					bundle.start  = clip(start_q);
					bundle.two    = 1'b1;
					count_n       = count_inc;
					if (count_q >= limit) begin
						bundle.kind1 = fasp_pkg::KIND_ERROR;
						halted_n     = 1'b1;
					end else begin
						bundle.kind1  = fasp_pkg::KIND_SENTINEL;
						bundle.symbol = fasp_pkg::sentinel_for(mode_q, count_q);
						position_n    = position_inc;
						start_n       = position_inc;
					end
				end
				in_header_n = 1'b1;
				has_name_n  = 1'b0;
				seq_open_n  = 1'b1;
				length_n    = '0;
			end else begin
				at_line_start_n = 1'b0;
				if (in_header_q) begin
					if (!fasp_pkg::is_blank(text_byte)) begin
						has_name_n = 1'b1;
					end
				end else if (seq_open_q && !fasp_pkg::is_blank(text_byte)) begin
					push = 1'b1;
					if (in_alpha) begin
						bundle.kind0  = fasp_pkg::KIND_RESIDUE;
						bundle.symbol = upper;
						length_n      = length_inc;
						position_n    = position_inc;
					end else begin
						bundle.kind0 = fasp_pkg::KIND_ERROR;
						bundle.code  = fasp_pkg::ERR_INVALID_RESIDUE;
						halted_n     = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= 1'b0;
			at_line_start_q <= 1'b1;
			in_header_q     <= 1'b0;
			has_name_q      <= 1'b0;
			seq_open_q      <= 1'b0;
			halted_q        <= 1'b0;
			length_q        <= '0;
			start_q         <= '0;
			position_q      <= '0;
			count_q         <= 8'd0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
			at_line_start_q <= at_line_start_n;
			in_header_q     <= in_header_n;
			has_name_q      <= has_name_n;
			seq_open_q      <= seq_open_n;
			halted_q        <= halted_n;
			length_q        <= length_n;
			start_q         <= start_n;
			position_q      <= position_n;
			count_q         <= count_n;
		end
	end

endmodule
`default_nettype wire

>>> design/fasp_queue.sv
// small bundle queue between the front end and the output stage
`default_nettype none
module fasp_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire fasp_pkg::bundle_t  push_data,
	input  wire logic               pop,
	output logic                    full,
	output logic                    empty,
	output fasp_pkg::bundle_t       head
);

	localparam int PTR_BITS = $clog2(fasp_pkg::QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(fasp_pkg::QUEUE_DEPTH + 1);

	fasp_pkg::bundle_t     mem [fasp_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  do_pop;

	assign full   = (count_q == CNT_BITS'(fasp_pkg::QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign head   = mem[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/fasp_back.sv
// back end: splits bundles into single results and holds the output register
`default_nettype none
module fasp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               queue_empty,
	input  wire fasp_pkg::bundle_t  head,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [1:0]              item_kind,
	output logic [7:0]              symbol,
	output logic [7:0]              record_number,
	output logic [31:0]             record_length,
	output logic [31:0]             record_start,
	output logic [1:0]              error_code,
	output logic                    last_of_run
);

	fasp_pkg::bundle_t held_q;
	logic              second_q;
	logic              valid_q;
	logic              load;
	logic [1:0]        kind_q;
	logic [7:0]        symbol_q;
	logic [7:0]        number_q;
	logic [31:0]       length_q;
	logic [31:0]       start_q;
	logic [1:0]        code_q;
	logic              last_q;

	assign load = !valid_q || !result_stall;
	assign pop  = load && !second_q && !queue_empty;

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				kind_q   <= held_q.kind1;
				symbol_q <= (held_q.kind1 == fasp_pkg::KIND_SENTINEL) ? held_q.symbol : 8'd0;
				number_q <= 8'd0;
				length_q <= 32'd0;
				start_q  <= 32'd0;
				code_q   <= (held_q.kind1 == fasp_pkg::KIND_ERROR) ?
				            fasp_pkg::ERR_TOO_MANY : fasp_pkg::ERR_INVALID_RESIDUE;
				last_q   <= 1'b1;
			end else if (!queue_empty) begin
				held_q   <= head;
				kind_q   <= head.kind0;
				symbol_q <= (head.kind0 == fasp_pkg::KIND_RESIDUE) ? head.symbol : 8'd0;
				number_q <= head.number;
				length_q <= head.length;
				start_q  <= head.start;
				code_q   <= head.code;
				last_q   <= !head.two;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				valid_q  <= 1'b1;
				second_q <= 1'b0;
			end else if (!queue_empty) begin
				valid_q  <= 1'b1;
				second_q <= head.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = valid_q;
	assign item_kind     = kind_q;
	assign symbol        = symbol_q;
	assign record_number = number_q;
	assign record_length = length_q;
	assign record_start  = start_q;
	assign error_code    = code_q;
	assign last_of_run   = last_q;

endmodule
`default_nettype wire

>>> design/fasta_residue_stream_parser.sv
// top level of the fasta residue stream parser
// path: a request's results are written into the queue and then loaded into the output register
// throughput: one text byte per cycle while the queue has room; a request with two results
// occupies the output for both, and a four-entry queue absorbs the gap before the input stalls
// reset: arst_n clears parse state, counters, queue and output valid; alphabet_mode returns to 0
`default_nettype none
module fasta_residue_stream_parser #(
	parameter int POSITION_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        text_valid,
	output logic             text_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_text,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        alphabet_mode,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       item_kind,
	output logic [7:0]       symbol,
	output logic [7:0]       record_number,
	output logic [31:0]      record_length,
	output logic [31:0]      record_start,
	output logic [1:0]       error_code,
	output logic             last_of_run
);

	logic              push;
	logic              pop;
	logic              queue_full;
	logic              queue_empty;
	fasp_pkg::bundle_t push_data;
	fasp_pkg::bundle_t head;

	assign cfg_ready  = 1'b1;
	assign text_stall = queue_full;

	fasp_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.queue_full (queue_full),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_mode   (alphabet_mode),
		.push       (push),
		.bundle     (push_data)
	);

	fasp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head     (head)
	);

	fasp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.item_kind    (item_kind),
		.symbol       (symbol),
		.record_number(record_number),
		.record_length(record_length),
		.record_start (record_start),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

endmodule
`default_nettype wire

>>> design/fasp_checker.sv
// port level checks for the fasta residue stream parser and their binding
`default_nettype none
module fasp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        result_valid,
	input  wire logic        result_stall,
	input  wire logic [1:0]  item_kind,
	input  wire logic [7:0]  symbol,
	input  wire logic [1:0]  error_code,
	input  wire logic        last_of_run
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(item_kind) && $stable(symbol))
		else $error("stalled result changed");

	// residues, sentinels and errors always end their request
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (item_kind == fasp_pkg::KIND_RESIDUE ||
		item_kind == fasp_pkg::KIND_SENTINEL || item_kind == fasp_pkg::KIND_ERROR)
		|-> last_of_run)
		else $error("result kind cannot be followed by another");

	// records carry no symbol and no error code
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind == fasp_pkg::KIND_RECORD |->
		symbol == 8'd0 && error_code == fasp_pkg::ERR_INVALID_RESIDUE)
		else $error("record with symbol or code");

	// an error halts the block
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && item_kind == fasp_pkg::KIND_ERROR |=> !result_valid)
		else $error("result after error");

endmodule

bind fasta_residue_stream_parser fasp_checker u_fasp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.item_kind   (item_kind),
	.symbol      (symbol),
	.error_code  (error_code),
	.last_of_run (last_of_run)
);
`default_nettype wire

>>> tb/tb_fasta_residue_stream_parser.sv
// testbench for the fasta residue stream parser: directed and random fasta texts checked by a scoreboard
`timescale 1ns / 1ps
module tb_fasta_residue_stream_parser;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLD_CYCLES    = 64;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 1750;
	localparam int TOO_MANY_ITEMS = 1300;

	typedef struct packed {
		fasp_pkg::kind_t kind;
		logic [7:0]      symbol;
		logic [7:0]      number;
		logic [31:0]     length;
		logic [31:0]     start;
		fasp_pkg::err_t  code;
		logic            last;
	} parse_result_t;

	class parse_scoreboard;
		logic          mode;
		bit            line_start, header_line, header_named, seq_open, halted;
		logic [31:0]   cur_len, cur_start, out_pos;
		logic [7:0]    seq_count;
		parse_result_t expected_q[$];
		parse_result_t held;
		bit            have_held;
		int            fails;

		function new();
			mode = 1'b0;
			fails = 0;
			have_held = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			line_start = 1;
			header_line = 0;
			header_named = 0;
			seq_open = 0;
			cur_len = '0;
			cur_start = '0;
			out_pos = '0;
			seq_count = '0;
			halted = 0;
		endfunction

		function void set_mode(logic m);
			mode = m;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function bit is_space(logic [7:0] b);
			return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
		endfunction

		function logic [7:0] fold_case(logic [7:0] b);
			return (b >= 8'd97 && b <= 8'd122) ? b - 8'd32 : b;
		endfunction

		function bit in_alphabet(logic [7:0] u);
			string letters;
			if (mode) begin
				letters = "ACDEFGHIKLMNPQRSTVWY";
			end else begin
				letters = "ACGT";
			end
			for (int i = 0; i < letters.len(); i++) begin
				if (letters[i] == u) begin
					return 1;
				end
			end
			return 0;
		endfunction

		function logic [7:0] sentinel_byte(logic [7:0] idx);
			logic [8:0] s;
			s = {1'b0, idx} + 9'd1;
			while (s < 9'd255 && in_alphabet(s[7:0])) begin
				s++;
			end
			return s[7:0];
		endfunction

		function logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		// the last result of a request is held back so its last flag can be set
		function void emit(fasp_pkg::kind_t kind, logic [7:0] sym, logic [7:0] num,
				logic [31:0] len, logic [31:0] start, fasp_pkg::err_t code);
			if (have_held) begin
				expected_q.insert(expected_q.size(), held);
			end
			held.kind = kind;
			held.symbol = sym;
			held.number = num;
			held.length = len;
			held.start = start;
			held.code = code;
			held.last = 1'b0;
			have_held = 1;
		endfunction

		function void emit_error(fasp_pkg::err_t code);
			halted = 1;
			emit(fasp_pkg::KIND_ERROR, 8'd0, 8'd0, 32'd0, 32'd0, code);
		endfunction

		// code field is zero outside errors
		function void emit_record();
			emit(fasp_pkg::KIND_RECORD, 8'd0, seq_count, cur_len, cur_start,
				fasp_pkg::ERR_INVALID_RESIDUE);
			if (seq_count != 8'hFF) begin
				seq_count++;
			end
		endfunction

		function void note_request(logic [7:0] b, logic eot);
			logic [7:0] idx, limit, u;
			if (halted) begin
				return;
			end
			have_held = 0;
			if (eot) begin
				if (header_line && !header_named) begin
					emit_error(fasp_pkg::ERR_EMPTY_HEADER);
				end else begin
					if (seq_open && cur_len != 0) begin
						emit_record();
					end
					if (seq_count == 0) begin
						emit_error(fasp_pkg::ERR_NO_SEQUENCES);
					end
				end
				if (!halted) begin
					clear_parse();
				end
			end else if (b == fasp_pkg::NEWLINE) begin
				if (header_line && !header_named) begin
					emit_error(fasp_pkg::ERR_EMPTY_HEADER);
				end
				header_line = 0;
				line_start = 1;
			end else if (line_start && b == fasp_pkg::HEADER_MARK) begin
				line_start = 0;
				if (seq_open && cur_len != 0) begin
					idx = seq_count;
					limit = mode ? fasp_pkg::AMINO_LIMIT : fasp_pkg::NUC_LIMIT;
					emit_record();
					if (idx >= limit) begin
						emit_error(fasp_pkg::ERR_TOO_MANY);
					end else begin
						emit(fasp_pkg::KIND_SENTINEL, sentinel_byte(idx), 8'd0, 32'd0, 32'd0,
							fasp_pkg::ERR_INVALID_RESIDUE);
						out_pos = bump(out_pos);
					end
				end
				header_line = 1;
				header_named = 0;
				seq_open = 1;
				cur_len = '0;
				cur_start = out_pos;
			end else begin
				line_start = 0;
				if (header_line) begin
					if (!is_space(b)) begin
						header_named = 1;
					end
				end else if (seq_open && !is_space(b)) begin
					u = fold_case(b);
					if (in_alphabet(u)) begin
						emit(fasp_pkg::KIND_RESIDUE, u, 8'd0, 32'd0, 32'd0,
							fasp_pkg::ERR_INVALID_RESIDUE);
						cur_len = bump(cur_len);
						out_pos = bump(out_pos);
					end else begin
						emit_error(fasp_pkg::ERR_INVALID_RESIDUE);
					end
				end
			end
			if (have_held) begin
				held.last = 1'b1;
				expected_q.insert(expected_q.size(), held);
				have_held = 0;
			end
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s expected %0d actual %0d", field, want, got);
				fails++;
			end
		endfunction

		function void check_result(parse_result_t got);
			parse_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no request waiting, item_kind %0d", got.kind);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			compare("item_kind", want.kind, got.kind);
			compare("symbol", want.symbol, got.symbol);
			compare("record_number", want.number, got.number);
			compare("record_length", want.length, got.length);
			compare("record_start", want.start, got.start);
			compare("error_code", want.code, got.code);
			compare("last_of_run", want.last, got.last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        text_valid;
	logic        text_stall;
	logic [7:0]  text_byte;
	logic        end_of_text;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        alphabet_mode;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  item_kind;
	logic [7:0]  symbol;
	logic [7:0]  record_number;
	logic [31:0] record_length;
	logic [31:0] record_start;
	logic [1:0]  error_code;
	logic        last_of_run;

	parse_scoreboard sb;
	parse_result_t   seen;
	int              cycle_count = 0;
	int              items_sent = 0;
	bit              idle_on = 1;
	bit              hold_request = 0;
	logic            cur_mode = 1'b0;

	fasta_residue_stream_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_valid    (text_valid),
		.text_stall    (text_stall),
		.text_byte     (text_byte),
		.end_of_text   (end_of_text),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.alphabet_mode (alphabet_mode),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.item_kind     (item_kind),
		.symbol        (symbol),
		.record_number (record_number),
		.record_length (record_length),
		.record_start  (record_start),
		.error_code    (error_code),
		.last_of_run   (last_of_run)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fasta_residue_stream_parser: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			seen.kind = fasp_pkg::kind_t'(item_kind);
			seen.symbol = symbol;
			seen.number = record_number;
			seen.length = record_length;
			seen.start = record_start;
			seen.code = fasp_pkg::err_t'(error_code);
			seen.last = last_of_run;
			sb.check_result(seen);
		end
	end

	// receiver: random stalls, or one long hold when asked
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_stall <= idle_on && ($urandom_range(0, 99) < 25);
			end
		end
	end

	// entered and left at a falling edge; valid stays high until the next call or a pause
	task automatic send_request(logic [7:0] b, logic eot);
		while (idle_on && $urandom_range(0, 99) < 25) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		do @(posedge clk); while (text_stall);
		sb.note_request(b, eot);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_string(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_request(s[i], 1'b0);
		end
	endtask

	task automatic quiesce();
		text_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(logic m);
		quiesce();
		cfg_valid <= 1'b1;
		alphabet_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		sb.set_mode(m);
		cur_mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_residue();
		logic [7:0] r;
		do r = 8'($urandom_range(65, 90)); while (!sb.in_alphabet(r));
		if ($urandom_range(0, 9) < 3) begin
			r = r + 8'd32;
		end
		return r;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0: begin
				return 8'd9;
			end
			1: begin
				return 8'd11;
			end
			2: begin
				return 8'd12;
			end
			3: begin
				return 8'd13;
			end
			default: begin
				return 8'd32;
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_name(bit solid);
		logic [7:0] r;
		do r = 8'($urandom_range(0, 255));
		while (r == fasp_pkg::NEWLINE || (solid && sb.is_space(r)));
		return r;
	endfunction

	task automatic send_header(bit named);
		send_request(fasp_pkg::HEADER_MARK, 1'b0);
		repeat ($urandom_range(0, 2)) send_request(pick_blank(), 1'b0);
		if (named) begin
			send_request(pick_name(1), 1'b0);
			repeat ($urandom_range(0, 6)) send_request(pick_name(0), 1'b0);
		end
	endtask

	task automatic send_preamble();
		logic [7:0] b;
		repeat ($urandom_range(1, 2)) begin
			b = pick_name(0);
			if (b == fasp_pkg::HEADER_MARK) begin
				b = 8'd35;
			end
			send_request(b, 1'b0);
			repeat ($urandom_range(0, 5)) send_request(pick_name(0), 1'b0);
			send_request(fasp_pkg::NEWLINE, 1'b0);
		end
	endtask

	task automatic send_residues(int count);
		int on_line, width;
		on_line = 0;
		width = $urandom_range(1, 12);
		for (int i = 0; i < count; i++) begin
			if (on_line >= width) begin
				send_request(fasp_pkg::NEWLINE, 1'b0);
				if ($urandom_range(0, 9) == 0) begin
					send_request(fasp_pkg::NEWLINE, 1'b0);
				end
				on_line = 0;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_request(pick_blank(), 1'b0);
			end
			if ($urandom_range(0, 199) == 0) begin
				quiesce();
			end
			send_request(pick_residue(), 1'b0);
			on_line++;
		end
	endtask

	// one well-formed text with at least one non-empty sequence
	task automatic send_text(int seqs, int max_len);
		int solid, len;
		bit last_seq;
		if ($urandom_range(0, 3) == 0) begin
			send_preamble();
		end
		solid = $urandom_range(0, seqs - 1);
		for (int s = 0; s < seqs; s++) begin
			last_seq = (s == seqs - 1);
			send_header(1);
			len = (s == solid) ? $urandom_range(1, max_len < 1 ? 1 : max_len)
				: $urandom_range(0, max_len);
			if (len > 0 || !last_seq || $urandom_range(0, 1)) begin
				send_request(fasp_pkg::NEWLINE, 1'b0);
			end
			send_residues(len);
			if (!last_seq || $urandom_range(0, 1)) begin
				send_request(fasp_pkg::NEWLINE, 1'b0);
			end
		end
		send_request(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		int text_no;
		int budget;
		logic [7:0] bad, limit;
		fasp_pkg::err_t final_err;
		sb = new();
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_byte = 8'd0;
		end_of_text = 1'b0;
		cfg_valid = 1'b0;
		alphabet_mode = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: junk before the first header, blanks, lower case, blank-led line,
		// header named only after a blank, eot with no trailing newline
		send_string("x>\n>a b\nAc\n t\n>\t>\ng");
		send_request(8'hFF, 1'b1);
		write_mode(1'b1);
		send_string(">p\nw\n>q\ny");
		send_request(8'h00, 1'b1);

		final_err = fasp_pkg::err_t'($urandom_range(0, 3));
		budget = RANDOM_ITEMS - ((final_err == fasp_pkg::ERR_TOO_MANY) ? TOO_MANY_ITEMS : 0);
		text_no = 0;
		while (items_sent < budget || text_no <= 4) begin
			if (text_no % 3 == 0) begin
				write_mode((text_no / 3) % 2 == 0 ? 1'b0 : 1'b1);
			end
			idle_on = !(text_no >= 8 && text_no < 14);
			if (text_no == 4) begin
				hold_request = 1;
				send_text(3, 40);
			end else if (text_no % 10 == 9) begin
				send_text($urandom_range(1, 3), 60);
			end else begin
				send_text($urandom_range(1, 6), $urandom_range(0, 15));
			end
			text_no++;
		end

		// one error ends the parse for good
		idle_on = (final_err != fasp_pkg::ERR_TOO_MANY);
		write_mode(logic'($urandom_range(0, 1)));
		case (final_err)
			fasp_pkg::ERR_INVALID_RESIDUE: begin
				send_header(1);
				send_request(fasp_pkg::NEWLINE, 1'b0);
				send_residues($urandom_range(1, 5));
				if ($urandom_range(0, 1)) begin
					send_request(fasp_pkg::NEWLINE, 1'b0);
					send_request(pick_blank(), 1'b0);
					send_request(fasp_pkg::HEADER_MARK, 1'b0);
				end else begin
					do bad = 8'($urandom_range(0, 255));
					while (bad == fasp_pkg::NEWLINE || sb.is_space(bad) ||
						sb.in_alphabet(sb.fold_case(bad)));
					send_request(bad, 1'b0);
				end
			end
			fasp_pkg::ERR_EMPTY_HEADER: begin
				send_header(1);
				send_request(fasp_pkg::NEWLINE, 1'b0);
				send_residues($urandom_range(1, 4));
				send_request(fasp_pkg::NEWLINE, 1'b0);
				send_header(0);
				send_request($urandom_range(0, 1) ? fasp_pkg::NEWLINE : 8'h41,
					logic'($urandom_range(0, 1)));
			end
			fasp_pkg::ERR_TOO_MANY: begin
				limit = cur_mode ? fasp_pkg::AMINO_LIMIT : fasp_pkg::NUC_LIMIT;
				for (int i = 0; i <= int'(limit); i++) begin
					send_string(">s\n");
					send_request(pick_residue(), 1'b0);
					send_request(fasp_pkg::NEWLINE, 1'b0);
				end
				send_request(fasp_pkg::HEADER_MARK, 1'b0);
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					send_preamble();
					send_header(1);
					send_request(fasp_pkg::NEWLINE, 1'b0);
				end
				send_request(8'($urandom_range(0, 255)), 1'b1);
			end
		endcase
		idle_on = 1;
		repeat (12) send_request(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

		quiesce();
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("fasta_residue_stream_parser: match");
		end else begin
			$display("fasta_residue_stream_parser: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/fasp_pkg.sv
design/fasp_front.sv
design/fasp_queue.sv
design/fasp_back.sv
design/fasta_residue_stream_parser.sv
design/fasp_checker.sv
tb/tb_fasta_residue_stream_parser.sv
